// File: hdl/indexed_double_ended_queue_top_defines.svh
// Assertion macros for the indexed double-ended queue.
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define IDQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("idq: property violated");
// Condition must never be seen outside reset.
`define IDQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("idq: forbidden condition seen");
`else
`define IDQ_ASSERT(lbl, clk, rstn, prop)
`define IDQ_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hdl/idq_pkg.sv
// Shared types and constants for the indexed double-ended queue.
`timescale 1ns / 1ps

package idq_pkg;

    // Beat field widths
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int READ_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT  = 3'd0,
        CMD_PUSH_BACK   = 3'd1,
        CMD_POP_FRONT   = 3'd2,
        CMD_POP_BACK    = 3'd3,
        CMD_READ_FRONT  = 3'd4,
        CMD_READ_BACK   = 3'd5,
        CMD_WRITE_FRONT = 3'd6,
        CMD_CLEAR       = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_APPLY
    } state_t;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic push_front;  // every cell takes its front-side neighbour
        logic pop_front;   // every cell takes its back-side neighbour
        logic wr_en;       // addressed cell takes the write word
    } cell_ctl_t;

endpackage

// File: hdl/idq_cell.sv
// One storage cell of the queue chain.
`timescale 1ns / 1ps

module idq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 4,
    parameter int IDX        = 0
) (
    input  logic                  aclk,
    input  idq_pkg::cell_ctl_t    ctl,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] front_data,
    input  logic [DATA_WIDTH-1:0] back_data,
    output logic [DATA_WIDTH-1:0] data_q
);

    localparam logic [ADDR_W-1:0] MY_ADDR = ADDR_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;

    // Shift towards the back, shift towards the front, or local write
    always_ff @(posedge aclk) begin
        if (ctl.push_front) begin
            data_reg <= front_data;
        end else if (ctl.pop_front) begin
            data_reg <= back_data;
        end else if (ctl.wr_en && (wr_addr == MY_ADDR)) begin
            data_reg <= wr_data;
        end
    end

    assign data_q = data_reg;

endmodule

// File: hdl/idq_chain.sv
// Row of queue cells with a two-level registered read-out.
`timescale 1ns / 1ps

module idq_chain #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 16
) (
    input  logic                     aclk,
    input  idq_pkg::cell_ctl_t       ctl,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]    wr_data,
    input  logic                     gather_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]    rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LOW_W  = (ADDR_W < 4) ? ADDR_W : 4;
    localparam int GRP    = 1 << LOW_W;
    localparam int HIGH_W = (ADDR_W > LOW_W) ? (ADDR_W - LOW_W) : 1;
    localparam int NSLOT  = 1 << HIGH_W;

    logic [DATA_WIDTH-1:0] cell_q     [DEPTH];
    logic [DATA_WIDTH-1:0] front_w    [DEPTH];
    logic [DATA_WIDTH-1:0] back_w     [DEPTH];
    logic [DATA_WIDTH-1:0] grp_sel    [NSLOT];
    logic [DATA_WIDTH-1:0] grp_reg    [NSLOT];
    logic [LOW_W-1:0]      rd_lo;
    logic [HIGH_W-1:0]     rd_hi;
    logic [HIGH_W-1:0]     hi_reg;

    // Cells, each wired to its two neighbours; the front end takes the push word
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign front_w[i] = wr_data;
        end else begin : g_body
            assign front_w[i] = cell_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign back_w[i] = cell_q[i];
        end else begin : g_inner
            assign back_w[i] = cell_q[i+1];
        end

        idq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .ADDR_W     (ADDR_W),
            .IDX        (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .wr_addr    (wr_addr),
            .wr_data    (wr_data),
            .front_data (front_w[i]),
            .back_data  (back_w[i]),
            .data_q     (cell_q[i])
        );
    end

    // Split read address into cell-in-group and group parts
    assign rd_lo = rd_addr[LOW_W-1:0];
    if (ADDR_W > LOW_W) begin : g_hi
        assign rd_hi = rd_addr[ADDR_W-1:LOW_W];
    end else begin : g_nohi
        assign rd_hi = 1'b0;
    end

    // First level: one cell out of each group of up to sixteen
    always_comb begin
        for (int g = 0; g < NSLOT; g++) begin
            grp_sel[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (((g * GRP + k) < DEPTH) && (rd_lo == LOW_W'(k))) begin
                    grp_sel[g] = cell_q[(g * GRP + k) % DEPTH];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (gather_en) begin
            for (int g = 0; g < NSLOT; g++) begin
                grp_reg[g] <= grp_sel[g];
            end
            hi_reg <= rd_hi;
        end
    end

    // Second level: pick the group
    assign rd_data = grp_reg[hi_reg];

endmodule

// File: hdl/indexed_double_ended_queue_top.sv
// Top level of the indexed double-ended queue.
`timescale 1ns / 1ps
`include "indexed_double_ended_queue_top_defines.svh"

// Bounded double-ended queue of DEPTH words held in a row of shifting cells;
// the front entry always sits in the first cell.
// Command channel (s_): one beat is one command - push/pop at either end,
// read at a position from either end, write at a position from the front,
// or clear. Result channel (m_): one beat per command with the read word,
// a status code and the number of entries held afterwards.
// Each command passes through accept, a gather cycle that latches one
// cell per group of up to sixteen, and an apply cycle that picks the group,
// updates the cells and count and loads the result register. The result
// beat is valid once the apply cycle has loaded that register; the block
// takes no new command until the apply cycle of the last one has fired.
// A result waits in the output register while the receiver stalls; the next
// command is still accepted and held in its apply cycle until that slot frees.
// Reset empties the queue and drops any pending result; stored words are
// left as they were and only become readable again once rewritten.
module indexed_double_ended_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], position [35:32], zero pad
    input  logic [2:0]  s_tuser,   // command [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_value [31:0], entry_total [36:32], zero pad
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = CNT_W + 4;

    idq_pkg::state_t    state_reg, state_next;
    idq_pkg::cmd_t      cmd_reg;
    logic [31:0]        value_reg;
    logic [3:0]         pos_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               m_valid_reg;
    logic [31:0]        out_read_reg;
    idq_pkg::status_t   out_status_reg;
    logic [4:0]         out_total_reg;

    logic               s_accept;
    logic               gather_en;
    logic               apply_fire;

    logic [EXT_W-1:0]   count_ext, pos_ext, back_ext, back_pos_ext;
    logic               is_full, is_empty, in_range;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [DATA_WIDTH+31:0] val_ext;
    logic [DATA_WIDTH-1:0]  wr_data, pick_data;
    logic [DATA_WIDTH+31:0] read_ext;
    logic [CNT_W+4:0]   total_ext;
    idq_pkg::cell_ctl_t op_ctl, cell_ctl;
    idq_pkg::status_t   status_c;
    logic               take_read;
    logic [31:0]        read_word;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= idq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idq_pkg::S_IDLE:   if (s_tvalid) state_next = idq_pkg::S_GATHER;
            idq_pkg::S_GATHER: state_next = idq_pkg::S_APPLY;
            idq_pkg::S_APPLY:  if (apply_fire) state_next = idq_pkg::S_IDLE;
            default:           state_next = idq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == idq_pkg::S_IDLE);
        gather_en  = (state_reg == idq_pkg::S_GATHER);
        apply_fire = (state_reg == idq_pkg::S_APPLY) && (!m_valid_reg || m_tready);
    end

    assign s_accept = s_tvalid && s_tready;

    // Command capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= idq_pkg::cmd_t'(s_tuser);
            value_reg <= s_tdata[31:0];
            pos_reg   <= s_tdata[35:32];
        end
    end

    // Ranges and addresses
    assign count_ext    = {4'd0, count_reg};
    assign pos_ext      = {{CNT_W{1'b0}}, pos_reg};
    assign back_ext     = count_ext - EXT_W'(1);
    assign back_pos_ext = back_ext - pos_ext;
    assign is_full      = (count_reg == CNT_W'(DEPTH));
    assign is_empty     = (count_reg == '0);
    assign in_range     = (pos_ext < count_ext);

    always_comb begin
        case (cmd_reg)
            idq_pkg::CMD_POP_BACK:   rd_addr = back_ext[ADDR_W-1:0];
            idq_pkg::CMD_READ_FRONT: rd_addr = pos_ext[ADDR_W-1:0];
            idq_pkg::CMD_READ_BACK:  rd_addr = back_pos_ext[ADDR_W-1:0];
            default:                 rd_addr = '0;
        endcase
    end

    assign val_ext = {{DATA_WIDTH{1'b0}}, value_reg};
    assign wr_data = val_ext[DATA_WIDTH-1:0];

    // Command decode: status, cell control and new count
    always_comb begin
        status_c   = idq_pkg::ST_OK;
        take_read  = 1'b0;
        op_ctl     = '0;
        wr_addr    = pos_ext[ADDR_W-1:0];
        count_next = count_reg;
        case (cmd_reg)
            idq_pkg::CMD_PUSH_FRONT: begin
                if (is_full) begin
                    status_c = idq_pkg::ST_FULL;
                end else begin
                    op_ctl.push_front = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                end
            end
            idq_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                    status_c = idq_pkg::ST_FULL;
                end else begin
                    op_ctl.wr_en = 1'b1;
                    wr_addr      = count_ext[ADDR_W-1:0];
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            idq_pkg::CMD_POP_FRONT: begin
                if (is_empty) begin
                    status_c = idq_pkg::ST_RANGE;
                end else begin
                    take_read        = 1'b1;
                    op_ctl.pop_front = 1'b1;
                    count_next       = count_reg - CNT_W'(1);
                end
            end
            idq_pkg::CMD_POP_BACK: begin
                if (is_empty) begin
                    status_c = idq_pkg::ST_RANGE;
                end else begin
                    take_read  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            idq_pkg::CMD_READ_FRONT, idq_pkg::CMD_READ_BACK: begin
                if (!in_range) begin
                    status_c = idq_pkg::ST_RANGE;
                end else begin
                    take_read = 1'b1;
                end
            end
            idq_pkg::CMD_WRITE_FRONT: begin
                if (!in_range) begin
                    status_c = idq_pkg::ST_RANGE;
                end else begin
                    op_ctl.wr_en = 1'b1;
                end
            end
            idq_pkg::CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    assign cell_ctl = apply_fire ? op_ctl : '0;

    // Cell row
    idq_chain #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_chain (
        .aclk      (aclk),
        .ctl       (cell_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .gather_en (gather_en),
        .rd_addr   (rd_addr),
        .rd_data   (pick_data)
    );

    assign read_ext  = {32'd0, pick_data};
    assign read_word = take_read ? read_ext[31:0] : 32'd0;
    assign total_ext = {5'd0, count_next};

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (apply_fire) begin
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (apply_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_fire) begin
            out_read_reg   <= read_word;
            out_status_reg <= status_c;
            out_total_reg  <= total_ext[4:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, out_total_reg, out_read_reg};
    assign m_tuser  = out_status_reg;

    // Checks
    `IDQ_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > CNT_W'(DEPTH))
    `IDQ_ASSERT(a_count_hold, aclk, aresetn, !apply_fire |=> $stable(count_reg))
    `IDQ_ASSERT(a_result_load, aclk, aresetn, apply_fire |=> m_tvalid)
    `IDQ_ASSERT(a_full_no_data, aclk, aresetn, (m_tvalid && (m_tuser == idq_pkg::ST_FULL)) |-> (m_tdata[31:0] == 32'd0))

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the indexed double-ended queue.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 1150;
    localparam int LONG_HOLD    = 160;
    localparam int HOLD_AFTER   = 300;     // results seen before the long hold-off
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int PRINT_LIMIT  = 20;
    localparam int N_ROWS       = 20;

    // One result beat as the queue should return it
    typedef struct packed {
        logic [31:0]      read_word;
        idq_pkg::status_t status;
        logic [4:0]       total;
    } queue_result_t;

    // One row of the directed sequence; a fixed row carries its result inline
    typedef struct packed {
        idq_pkg::cmd_t    op;
        logic [31:0]      word;
        logic [3:0]       pos;
        int               reps;
        bit               fixed;
        logic [31:0]      exp_word;
        idq_pkg::status_t exp_status;
        logic [4:0]       exp_total;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // value [31:0], position [35:32], zero pad
    logic [2:0]  s_tuser  = idq_pkg::CMD_PUSH_FRONT;    // command [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // read_value [31:0], entry_total [36:32], zero pad
    logic [1:0]  m_tuser;          // status [1:0]

    // Predictor state: ring of words, front index and fill level
    logic [31:0] ring [DEPTH];
    int          front_idx = 0;
    int          held      = 0;

    queue_result_t expected_results [$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int cmds_sent      = 0;
    int full_rejects   = 0;
    int range_rejects  = 0;
    int burst_left     = 0;

    stim_row_t directed_rows [N_ROWS] = '{
        '{idq_pkg::CMD_POP_BACK,    32'h0, 4'd0,  1,  1'b1, 32'h0, idq_pkg::ST_RANGE, 5'd0},
        '{idq_pkg::CMD_READ_BACK,   32'h0, 4'd15, 1,  1'b1, 32'h0, idq_pkg::ST_RANGE, 5'd0},
        '{idq_pkg::CMD_WRITE_FRONT, 32'h1234_5678, 4'd0, 1, 1'b1, 32'h0,
          idq_pkg::ST_RANGE, 5'd0},
        '{idq_pkg::CMD_PUSH_BACK,   32'hFFFF_FFFF, 4'd0, 1, 1'b1, 32'h0, idq_pkg::ST_OK, 5'd1},
        '{idq_pkg::CMD_PUSH_FRONT,  32'h0, 4'd0,  1,  1'b1, 32'h0, idq_pkg::ST_OK,    5'd2},
        '{idq_pkg::CMD_READ_BACK,   32'h0, 4'd0,  1,  1'b1, 32'hFFFF_FFFF,
          idq_pkg::ST_OK, 5'd2},
        '{idq_pkg::CMD_WRITE_FRONT, 32'hA5A5_A5A5, 4'd1, 1, 1'b0, 32'h0, idq_pkg::ST_OK, 5'd0},
        '{idq_pkg::CMD_READ_FRONT,  32'h0, 4'd2,  1,  1'b1, 32'h0, idq_pkg::ST_RANGE, 5'd2},
        '{idq_pkg::CMD_POP_BACK,    32'h0, 4'd0,  1,  1'b0, 32'h0, idq_pkg::ST_OK,    5'd0},
        '{idq_pkg::CMD_POP_FRONT,   32'h0, 4'd0,  1,  1'b0, 32'h0, idq_pkg::ST_OK,    5'd0},
        '{idq_pkg::CMD_POP_FRONT,   32'h0, 4'd0,  1,  1'b1, 32'h0, idq_pkg::ST_RANGE, 5'd0},
        '{idq_pkg::CMD_PUSH_FRONT,  32'h0, 4'd0,  15, 1'b0, 32'h0, idq_pkg::ST_OK,    5'd0},
        '{idq_pkg::CMD_PUSH_BACK,   32'h8000_0001, 4'd0, 1, 1'b0, 32'h0, idq_pkg::ST_OK, 5'd0},
        '{idq_pkg::CMD_PUSH_FRONT,  32'hDEAD_BEEF, 4'd0, 1, 1'b1, 32'h0,
          idq_pkg::ST_FULL, 5'd16},
        '{idq_pkg::CMD_PUSH_BACK,   32'h0000_0001, 4'd0, 1, 1'b1, 32'h0,
          idq_pkg::ST_FULL, 5'd16},
        '{idq_pkg::CMD_READ_FRONT,  32'h0, 4'd15, 1,  1'b0, 32'h0, idq_pkg::ST_OK,    5'd0},
        '{idq_pkg::CMD_WRITE_FRONT, 32'hFFFF_FFFF, 4'd15, 1, 1'b0, 32'h0,
          idq_pkg::ST_OK, 5'd0},
        '{idq_pkg::CMD_READ_BACK,   32'h0, 4'd0,  1,  1'b0, 32'h0, idq_pkg::ST_OK,    5'd0},
        '{idq_pkg::CMD_CLEAR,       32'h0, 4'd0,  1,  1'b1, 32'h0, idq_pkg::ST_OK,    5'd0},
        '{idq_pkg::CMD_READ_FRONT,  32'h0, 4'd0,  1,  1'b1, 32'h0, idq_pkg::ST_RANGE, 5'd0}
    };

    indexed_double_ended_queue_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock and cycle counter
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Applies one command to the predicted queue and returns its result
    function automatic queue_result_t deque_apply(idq_pkg::cmd_t op, logic [31:0] word,
                                                  logic [3:0] pos);
        queue_result_t res;
        res.read_word = '0;
        res.status    = idq_pkg::ST_OK;
        case (op)
            idq_pkg::CMD_PUSH_FRONT: begin
                if (held == DEPTH) begin
                    res.status = idq_pkg::ST_FULL;
                end else begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    ring[front_idx] = word;
                    held++;
                end
            end
            idq_pkg::CMD_PUSH_BACK: begin
                if (held == DEPTH) begin
                    res.status = idq_pkg::ST_FULL;
                end else begin
                    ring[(front_idx + held) % DEPTH] = word;
                    held++;
                end
            end
            idq_pkg::CMD_POP_FRONT: begin
                if (held == 0) begin
                    res.status = idq_pkg::ST_RANGE;
                end else begin
                    res.read_word = ring[front_idx];
                    front_idx = (front_idx + 1) % DEPTH;
                    held--;
                end
            end
            idq_pkg::CMD_POP_BACK: begin
                if (held == 0) begin
                    res.status = idq_pkg::ST_RANGE;
                end else begin
                    res.read_word = ring[(front_idx + held - 1) % DEPTH];
                    held--;
                end
            end
            idq_pkg::CMD_READ_FRONT: begin
                if (int'(pos) >= held) res.status = idq_pkg::ST_RANGE;
                else res.read_word = ring[(front_idx + int'(pos)) % DEPTH];
            end
            idq_pkg::CMD_READ_BACK: begin
                if (int'(pos) >= held) res.status = idq_pkg::ST_RANGE;
                else res.read_word = ring[(front_idx + held - 1 - int'(pos)) % DEPTH];
            end
            idq_pkg::CMD_WRITE_FRONT: begin
                if (int'(pos) >= held) res.status = idq_pkg::ST_RANGE;
                else ring[(front_idx + int'(pos)) % DEPTH] = word;
            end
            default: begin
                front_idx = 0;
                held      = 0;
            end
        endcase
        if (res.status == idq_pkg::ST_FULL) full_rejects++;
        if (res.status == idq_pkg::ST_RANGE) range_rejects++;
        res.total = 5'(held);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Offers one command beat in bursts with random gaps, predicts on acceptance
    task automatic send_cmd(input idq_pkg::cmd_t op, input logic [31:0] word,
                            input logic [3:0] pos,
                            input bit use_fixed, input queue_result_t fixed_res);
        int            gap;
        queue_result_t predicted;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 14);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pos, word};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = deque_apply(op, word, pos);
        expected_results.push_back(use_fixed ? fixed_res : predicted);
        cmds_sent++;
    endtask

    // Result receiver: stall pattern of its own, plus one long hold-off
    initial begin : result_sink
        int stall_pct;
        int span;
        bit long_done;
        long_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 80;
            endcase
            span = $urandom_range(16, 96);
            repeat (span) begin
                if (!long_done && results_seen >= HOLD_AFTER) begin
                    long_done = 1'b1;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge aclk);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat, read_value", m_tdata[31:0], 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.read_word)
                    report_mismatch("read_value", m_tdata[31:0], want.read_word);
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[36:32] !== want.total)
                    report_mismatch("entry_total", 32'(m_tdata[36:32]), 32'(want.total));
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run timed out after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("Mismatches found");
        $finish;
    end

    // Stimulus: reset, directed rows, then random traffic
    initial begin : stimulus
        queue_result_t fixed_res;
        queue_result_t no_res;
        stim_row_t     row;
        idq_pkg::cmd_t op;
        logic [31:0]   word;
        logic [3:0]    pos;
        int            pick;
        int            mode_left;
        bit            filling;
        no_res    = '{32'h0, idq_pkg::ST_OK, 5'd0};
        mode_left = 0;
        filling   = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        foreach (directed_rows[i]) begin
            row       = directed_rows[i];
            fixed_res = '{row.exp_word, row.exp_status, row.exp_total};
            for (int k = 0; k < row.reps; k++) begin
                word = (row.reps > 1) ? $urandom() : row.word;
                send_cmd(row.op, word, row.pos, row.fixed, fixed_res);
            end
        end

        // Random part, alternating between filling and draining phases
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                filling   = ~filling;
                mode_left = $urandom_range(40, 120);
            end
            mode_left--;

            pos = 4'($urandom_range(0, 15));
            if (held > 0 && $urandom_range(0, 99) < 85) pos = 4'($urandom_range(0, held - 1));

            case ($urandom_range(0, 9))
                0:       word = 32'h0000_0000;
                1:       word = 32'hFFFF_FFFF;
                default: word = $urandom();
            endcase

            pick = $urandom_range(0, 99);
            if (pick < (filling ? 45 : 20))
                op = pick[0] ? idq_pkg::CMD_PUSH_BACK : idq_pkg::CMD_PUSH_FRONT;
            else if (pick < (filling ? 60 : 55))
                op = pick[0] ? idq_pkg::CMD_POP_BACK : idq_pkg::CMD_POP_FRONT;
            else if (pick < 80)
                op = pick[0] ? idq_pkg::CMD_READ_BACK : idq_pkg::CMD_READ_FRONT;
            else if (pick < 98)
                op = idq_pkg::CMD_WRITE_FRONT;
            else
                op = idq_pkg::CMD_CLEAR;

            send_cmd(op, word, pos, 1'b0, no_res);
        end
        s_tvalid <= 1'b0;

        // Let the last results drain
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d commands and checked %0d result beats over %0d cycles",
                 cmds_sent, results_seen, cycle_count);
        $display("Pushes refused on a full queue: %0d, empty or out-of-range accesses: %0d",
                 full_rejects, range_rejects);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
